/* rtl/prl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

	// Slot table geometry; the slot field widths follow from the slot count
	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int LINK_W     = SLOT_W + 1;
	localparam int PRIO_REQ_W = 8;

	// Link value for "no slot" / empty list
	localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(TASK_SLOTS);

	// Commands
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_INSERT  = 2'd1;
	localparam logic [1:0] CMD_SUSPEND = 2'd2;
	localparam logic [1:0] CMD_RESUME  = 2'd3;

	// Result status
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_WRONG_LIST = 2'd2;
	localparam logic [1:0] ST_LAST_READY = 2'd3;

	// List membership of a slot
	localparam logic [1:0] LIST_NONE  = 2'd0;
	localparam logic [1:0] LIST_READY = 2'd1;
	localparam logic [1:0] LIST_SUSP  = 2'd2;

	typedef struct packed {
		logic [1:0]            command;
		logic [SLOT_W-1:0]     task_index;
		logic [PRIO_REQ_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] task_id;
		logic [LINK_W-1:0] ready_head;
		logic [1:0]        status;
	} rsp_t;

	// Datapath steps issued by the controller
	typedef struct packed {
		logic load;
		logic create;
		logic check;
		logic eval;
		logic susp_a;
		logic susp_b;
		logic susp_c;
		logic walk_rd;
		logic walk_cmp;
		logic link_a;
		logic link_b;
		logic finish;
	} ctl_t;

	// Datapath flags seen by the controller
	typedef struct packed {
		logic [1:0] command;
		logic       fail;
		logic       cur_none;
		logic       walk_more;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/prl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module prl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      command,
	input  prl_pkg::dp_stat_t stat,
	input  logic            out_free,
	output prl_pkg::ctl_t   ctl,
	output logic            idle
);
	import prl_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_CREATE   = 12'b0000_0000_0010,
		S_CHECK    = 12'b0000_0000_0100,
		S_EVAL     = 12'b0000_0000_1000,
		S_SUSP_A   = 12'b0000_0001_0000,
		S_SUSP_B   = 12'b0000_0010_0000,
		S_SUSP_C   = 12'b0000_0100_0000,
		S_WALK_RD  = 12'b0000_1000_0000,
		S_WALK_CMP = 12'b0001_0000_0000,
		S_LINK_A   = 12'b0010_0000_0000,
		S_LINK_B   = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (command == CMD_CREATE) ? S_CREATE : S_CHECK;
				end
			end
			S_CREATE:   state_d = S_DONE;
			S_CHECK:    state_d = stat.fail ? S_DONE : S_EVAL;
			S_EVAL: begin
				if (stat.fail) begin
					state_d = S_DONE;
				end else begin
					state_d = (stat.command == CMD_SUSPEND) ? S_SUSP_A : S_WALK_RD;
				end
			end
			S_SUSP_A:   state_d = S_SUSP_B;
			S_SUSP_B:   state_d = S_SUSP_C;
			S_SUSP_C:   state_d = S_DONE;
			S_WALK_RD:  state_d = stat.cur_none ? S_LINK_A : S_WALK_CMP;
			S_WALK_CMP: state_d = stat.walk_more ? S_WALK_RD : S_LINK_A;
			S_LINK_A:   state_d = S_LINK_B;
			S_LINK_B:   state_d = S_DONE;
			S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.load     = idle && req_valid;
		ctl.create   = (state_q == S_CREATE);
		ctl.check    = (state_q == S_CHECK);
		ctl.eval     = (state_q == S_EVAL);
		ctl.susp_a   = (state_q == S_SUSP_A);
		ctl.susp_b   = (state_q == S_SUSP_B);
		ctl.susp_c   = (state_q == S_SUSP_C);
		ctl.walk_rd  = (state_q == S_WALK_RD);
		ctl.walk_cmp = (state_q == S_WALK_CMP);
		ctl.link_a   = (state_q == S_LINK_A);
		ctl.link_b   = (state_q == S_LINK_B);
		ctl.finish   = (state_q == S_DONE) && out_free;
	end

endmodule

`default_nettype wire

/* rtl/prl_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module prl_dpath #(
	parameter int PRIORITY_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prl_pkg::req_t     req,
	input  prl_pkg::ctl_t     ctl,
	output prl_pkg::dp_stat_t stat,
	output prl_pkg::rsp_t     result
);
	import prl_pkg::*;

	localparam int ExtW = PRIORITY_BITS + PRIO_REQ_W;

	// Slot table, one write and one registered read per store and cycle
	logic [PRIORITY_BITS-1:0] prio_mem [TASK_SLOTS];
	logic [LINK_W-1:0]        next_mem [TASK_SLOTS];
	logic [LINK_W-1:0]        prev_mem [TASK_SLOTS];
	logic [1:0]               list_mem [TASK_SLOTS];

	logic [PRIORITY_BITS-1:0] rd_prio_q;
	logic [LINK_W-1:0]        rd_next_q;
	logic [LINK_W-1:0]        rd_prev_q;
	logic [1:0]               rd_list_q;

	logic [LINK_W-1:0] ready_first_q;
	logic [LINK_W-1:0] susp_first_q;
	logic [LINK_W-1:0] slots_used_q;

	logic [1:0]               cmd_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [PRIO_REQ_W-1:0]    prio_req_q;
	logic [PRIORITY_BITS-1:0] newp_q;
	logic [LINK_W-1:0]        cur_q;
	logic [LINK_W-1:0]        before_q;
	logic [SLOT_W-1:0]        id_q;
	logic [1:0]               status_q;

	logic [ExtW-1:0]          prio_ext;
	logic                     table_full;
	logic                     idx_unused;
	logic                     is_susp;
	logic                     fail;
	logic                     resume_ok;
	logic [SLOT_W-1:0]        rd_addr;
	logic [LINK_W-1:0]        slot_link;

	logic                     prio_we;
	logic [SLOT_W-1:0]        prio_waddr;
	logic                     next_we, prev_we, list_we;
	logic [SLOT_W-1:0]        next_waddr, prev_waddr, list_waddr;
	logic [LINK_W-1:0]        next_wdata, prev_wdata;
	logic [1:0]               list_wdata;

	assign prio_ext   = ExtW'(prio_req_q);
	assign table_full = (slots_used_q == LINK_W'(TASK_SLOTS));
	assign idx_unused = ({1'b0, slot_q} >= slots_used_q);
	assign is_susp    = (cmd_q == CMD_SUSPEND);
	assign slot_link  = {1'b0, slot_q};

	always_comb begin
		fail = 1'b0;
		if (ctl.check) begin
			fail = is_susp ? (ready_first_q == NO_SLOT) : idx_unused;
		end else if (ctl.eval) begin
			priority case (cmd_q)
				CMD_INSERT:  fail = (rd_list_q != LIST_NONE);
				CMD_RESUME:  fail = (rd_list_q != LIST_SUSP);
				default:     fail = (rd_next_q == NO_SLOT);
			endcase
		end
	end

	assign resume_ok = ctl.eval && (cmd_q == CMD_RESUME) && !fail;

	assign stat.command   = cmd_q;
	assign stat.fail      = fail;
	assign stat.cur_none  = (cur_q == NO_SLOT);
	assign stat.walk_more = (rd_prio_q < newp_q);

	always_comb begin
		if (ctl.check && is_susp) begin
			rd_addr = ready_first_q[SLOT_W-1:0];
		end else if (ctl.walk_rd) begin
			rd_addr = cur_q[SLOT_W-1:0];
		end else begin
			rd_addr = slot_q;
		end
	end

	// Write ports; the steps exclude each other
	always_comb begin
		prio_we    = ctl.create && !table_full;
		prio_waddr = slots_used_q[SLOT_W-1:0];

		next_we    = 1'b0;
		next_waddr = slot_q;
		next_wdata = NO_SLOT;
		prev_we    = 1'b0;
		prev_waddr = slot_q;
		prev_wdata = NO_SLOT;
		list_we    = 1'b0;
		list_waddr = slot_q;
		list_wdata = LIST_NONE;

		if (ctl.create && !table_full) begin
			next_we    = 1'b1;
			next_waddr = slots_used_q[SLOT_W-1:0];
			prev_we    = 1'b1;
			prev_waddr = slots_used_q[SLOT_W-1:0];
			list_we    = 1'b1;
			list_waddr = slots_used_q[SLOT_W-1:0];
		end else if (resume_ok) begin
			// unlink from the suspended list
			next_we    = (rd_prev_q != NO_SLOT);
			next_waddr = rd_prev_q[SLOT_W-1:0];
			next_wdata = rd_next_q;
			prev_we    = (rd_next_q != NO_SLOT);
			prev_waddr = rd_next_q[SLOT_W-1:0];
			prev_wdata = rd_prev_q;
		end else if (ctl.susp_a) begin
			next_we    = 1'b1;
			next_wdata = susp_first_q;
			prev_we    = 1'b1;
			prev_waddr = cur_q[SLOT_W-1:0];
			list_we    = 1'b1;
			list_wdata = LIST_SUSP;
		end else if (ctl.susp_b) begin
			prev_we    = 1'b1;
		end else if (ctl.susp_c) begin
			prev_we    = (susp_first_q != NO_SLOT);
			prev_waddr = susp_first_q[SLOT_W-1:0];
			prev_wdata = slot_link;
		end else if (ctl.link_a) begin
			next_we    = 1'b1;
			next_wdata = cur_q;
			prev_we    = 1'b1;
			prev_wdata = before_q;
			list_we    = 1'b1;
			list_wdata = LIST_READY;
		end else if (ctl.link_b) begin
			next_we    = (before_q != NO_SLOT);
			next_waddr = before_q[SLOT_W-1:0];
			next_wdata = slot_link;
			prev_we    = (cur_q != NO_SLOT);
			prev_waddr = cur_q[SLOT_W-1:0];
			prev_wdata = slot_link;
		end
	end

	always_ff @(posedge clk) begin
		if (prio_we) begin
			prio_mem[prio_waddr] <= prio_ext[PRIORITY_BITS-1:0];
		end
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		rd_prio_q <= prio_mem[rd_addr];
		rd_next_q <= next_mem[rd_addr];
		rd_prev_q <= prev_mem[rd_addr];
		rd_list_q <= list_mem[rd_addr];
	end

	// List heads and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_first_q <= NO_SLOT;
			susp_first_q  <= NO_SLOT;
			slots_used_q  <= '0;
		end else begin
			if (ctl.create && !table_full) begin
				slots_used_q <= slots_used_q + LINK_W'(1);
			end
			if (resume_ok && (rd_prev_q == NO_SLOT)) begin
				susp_first_q <= rd_next_q;
			end
			if (ctl.susp_a) begin
				ready_first_q <= cur_q;
			end
			if (ctl.susp_c) begin
				susp_first_q <= slot_link;
			end
			if (ctl.link_a && (before_q == NO_SLOT)) begin
				ready_first_q <= slot_link;
			end
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= req.command;
			slot_q     <= req.task_index;
			prio_req_q <= req.priority_req;
			status_q   <= ST_OK;
			if ((req.command == CMD_CREATE) || (req.command == CMD_SUSPEND)) begin
				id_q <= '0;
			end else begin
				id_q <= req.task_index;
			end
		end
		if (ctl.create) begin
			if (table_full) begin
				status_q <= ST_FULL;
			end else begin
				id_q <= slots_used_q[SLOT_W-1:0];
			end
		end
		if (ctl.check) begin
			if (is_susp) begin
				slot_q <= ready_first_q[SLOT_W-1:0];
			end
			if (fail) begin
				status_q <= is_susp ? ST_LAST_READY : ST_WRONG_LIST;
			end
		end
		if (ctl.eval) begin
			if (fail) begin
				status_q <= is_susp ? ST_LAST_READY : ST_WRONG_LIST;
			end else if (is_susp) begin
				cur_q <= rd_next_q;
				id_q  <= slot_q;
			end else begin
				newp_q   <= rd_prio_q;
				cur_q    <= ready_first_q;
				before_q <= NO_SLOT;
			end
		end
		if (ctl.walk_cmp && stat.walk_more) begin
			before_q <= cur_q;
			cur_q    <= rd_next_q;
		end
	end

	assign result.task_id    = id_q;
	assign result.ready_head = ready_first_q;
	assign result.status     = status_q;

`ifndef SYNTHESIS
	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= LINK_W'(TASK_SLOTS))
		else $error("slot fill count beyond table size");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.create && table_full) |=> (status_q == ST_FULL) && $stable(slots_used_q))
		else $error("create on full table changed state");

	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.link_a |-> ((before_q != cur_q) || (cur_q == NO_SLOT)))
		else $error("insert neighbors are the same slot");
`endif

endmodule

`default_nettype wire

/* rtl/priority_ready_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// Task scheduler over a table of sixteen slots, each holding a priority
// and the links of a doubly linked list. Create hands out the next free
// slot, insert puts a created slot into the ready list (sorted by
// priority, lowest number first, a new entry ahead of equal ones),
// suspend moves the ready head onto the head of the suspended list, and
// resume moves a suspended slot back into the ready list. Every command
// gives exactly one result item: the slot acted on, the ready head after
// the command (16 when empty) and a status (ok, table full, slot not in
// the expected list, or a suspend that would empty the ready list). The
// block works on one command at a time. Create writes the next free slot,
// suspend relinks the ready head onto the suspended list, and insert or
// resume walks the ready list from its head, reading one entry at a time
// through the single registered read port of the slot table until it
// meets the tail or the first entry whose priority number is not smaller
// than the new one; a command rejected on its first check or on the
// slot's list ends there. A finished result sits in an output register,
// so the next command is taken while the result still waits to be taken;
// a command that finishes while that register is still held waits for
// it. PRIORITY_BITS sets how many low bits of the requested priority are
// kept.
module priority_ready_list #(
	parameter int PRIORITY_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  prl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output prl_pkg::rsp_t rsp
);
	import prl_pkg::*;

	ctl_t     ctl;
	dp_stat_t stat;
	rsp_t     result;
	logic     idle;
	logic     out_free;

	logic     rsp_valid_q;
	rsp_t     rsp_q;

	// The output slot frees when empty or when its item leaves this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Take a new command only when the sequencer is idle
	assign req_stall = !idle;

	prl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (req.command),
		.stat      (stat),
		.out_free  (out_free),
		.ctl       (ctl),
		.idle      (idle)
	);

	prl_dpath #(
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.result (result)
	);

	// Output register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second item taken while a command is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(rsp_valid_q && rsp_stall))
		else $error("result overwrites an item not yet taken");
`endif

endmodule

`default_nettype wire

/* bench/priority_ready_list_checker.sv */
`timescale 1ns / 1ps

module priority_ready_list_checker import prl_pkg::*; #(
	parameter int PRIORITY_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  rsp_t                  rsp,
	output int                    errors,
	output int                    pending,
	output logic [TASK_SLOTS-1:0] susp_mask,
	output logic [TASK_SLOTS-1:0] idle_mask
);

	localparam logic [PRIO_REQ_W-1:0] PRIO_MASK = PRIO_REQ_W'((1 << PRIORITY_BITS) - 1);

	// Shadow copy of the slot table and both lists
	logic [PRIO_REQ_W-1:0] slot_prio [TASK_SLOTS];
	logic [LINK_W-1:0]     link_next [TASK_SLOTS];
	logic [LINK_W-1:0]     link_prev [TASK_SLOTS];
	logic [1:0]            slot_home [TASK_SLOTS];
	logic [LINK_W-1:0]     ready_top;
	logic [LINK_W-1:0]     susp_top;
	int                    created;

	rsp_t owed_results [$];
	int   mismatches;

	assign errors = mismatches;

	// Sorted insert: walk past strictly more urgent entries only
	task automatic link_into_ready(input logic [SLOT_W-1:0] s);
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] ahead;
		int                steps;
		cur   = ready_top;
		ahead = NO_SLOT;
		steps = 0;
		while (cur < NO_SLOT && steps < TASK_SLOTS &&
		       slot_prio[cur[SLOT_W-1:0]] < slot_prio[s]) begin
			ahead = cur;
			cur   = link_next[cur[SLOT_W-1:0]];
			steps++;
		end
		link_prev[s] = ahead;
		link_next[s] = cur;
		if (ahead < NO_SLOT) begin
			link_next[ahead[SLOT_W-1:0]] = LINK_W'(s);
		end else begin
			ready_top = LINK_W'(s);
		end
		if (cur < NO_SLOT) begin
			link_prev[cur[SLOT_W-1:0]] = LINK_W'(s);
		end
		slot_home[s] = LIST_READY;
	endtask

	task automatic run_command(input req_t c, output rsp_t r);
		logic [LINK_W-1:0] h;
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		r.task_id = '0;
		r.status  = ST_OK;
		case (c.command)
			CMD_CREATE: begin
				if (created >= TASK_SLOTS) begin
					r.status = ST_FULL;
				end else begin
					r.task_id          = SLOT_W'(created);
					slot_prio[created] = c.priority_req & PRIO_MASK;
					link_next[created] = NO_SLOT;
					link_prev[created] = NO_SLOT;
					slot_home[created] = LIST_NONE;
					created++;
				end
			end
			CMD_INSERT: begin
				r.task_id = c.task_index;
				if (int'(c.task_index) >= created || slot_home[c.task_index] != LIST_NONE) begin
					r.status = ST_WRONG_LIST;
				end else begin
					link_into_ready(c.task_index);
				end
			end
			CMD_SUSPEND: begin
				h = ready_top;
				if (h >= NO_SLOT || link_next[h[SLOT_W-1:0]] >= NO_SLOT) begin
					r.status = ST_LAST_READY;
				end else begin
					r.task_id = h[SLOT_W-1:0];
					ready_top = link_next[h[SLOT_W-1:0]];
					link_prev[ready_top[SLOT_W-1:0]] = NO_SLOT;
					link_next[h[SLOT_W-1:0]] = susp_top;
					link_prev[h[SLOT_W-1:0]] = NO_SLOT;
					if (susp_top < NO_SLOT) begin
						link_prev[susp_top[SLOT_W-1:0]] = h;
					end
					susp_top = h;
					slot_home[h[SLOT_W-1:0]] = LIST_SUSP;
				end
			end
			default: begin
				r.task_id = c.task_index;
				if (slot_home[c.task_index] != LIST_SUSP) begin
					r.status = ST_WRONG_LIST;
				end else begin
					// unlink from the suspended list, then sort into ready
					p = link_prev[c.task_index];
					n = link_next[c.task_index];
					if (p < NO_SLOT) begin
						link_next[p[SLOT_W-1:0]] = n;
					end else begin
						susp_top = n;
					end
					if (n < NO_SLOT) begin
						link_prev[n[SLOT_W-1:0]] = p;
					end
					link_into_ready(c.task_index);
				end
			end
		endcase
		r.ready_head = ready_top;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t                  want;
		logic [TASK_SLOTS-1:0] sm;
		logic [TASK_SLOTS-1:0] im;
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				slot_prio[i] = '0;
				link_next[i] = NO_SLOT;
				link_prev[i] = NO_SLOT;
				slot_home[i] = LIST_NONE;
			end
			ready_top = NO_SLOT;
			susp_top  = NO_SLOT;
			created   = 0;
			owed_results.delete();
			mismatches = 0;
			pending   <= 0;
			susp_mask <= '0;
			idle_mask <= '0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none outstanding: task_id=%0d ready_head=%0d status=%0d",
						         $time, rsp.task_id, rsp.ready_head, rsp.status);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (rsp.task_id !== want.task_id || rsp.ready_head !== want.ready_head ||
					    rsp.status !== want.status) begin
						if (mismatches < 10)
							$display("%0t: mismatch task_id %0d/%0d ready_head %0d/%0d status %0d/%0d (exp/got)",
							         $time, want.task_id, rsp.task_id, want.ready_head,
							         rsp.ready_head, want.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				run_command(req, want);
				owed_results.push_back(want);
			end
			for (int i = 0; i < TASK_SLOTS; i++) begin
				sm[i] = (slot_home[i] == LIST_SUSP);
				im[i] = (i < created) && (slot_home[i] == LIST_NONE);
			end
			pending   <= owed_results.size();
			susp_mask <= sm;
			idle_mask <= im;
		end
	end

endmodule

/* bench/priority_ready_list_tb.sv */
`timescale 1ns / 1ps

module priority_ready_list_tb;
	import prl_pkg::*;

	localparam int PRIORITY_BITS = 8;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int TAIL_CYCLES   = 60;
	localparam int PHASE_ITEMS   = 450;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int                    errors;
	int                    pending;
	logic [TASK_SLOTS-1:0] susp_mask;
	logic [TASK_SLOTS-1:0] idle_mask;

	// Idle rates for the current phase, in percent per cycle
	int src_idle_pct = 0;
	int rx_stall_pct = 0;

	// Long receiver hold-off: a request count and its acknowledge
	int hold_req  = 0;
	int hold_ack  = 0;
	int hold_left = 0;

	priority_ready_list #(
		.PRIORITY_BITS(PRIORITY_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	priority_ready_list_checker #(
		.PRIORITY_BITS(PRIORITY_BITS)
	) sched_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.errors   (errors),
		.pending  (pending),
		.susp_mask(susp_mask),
		.idle_mask(idle_mask)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: a pending hold-off request wins over random stalls; hold
	// stall high for the whole stretch so the block backs up into its input
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	function automatic req_t make_item(input logic [1:0] cmd, input logic [SLOT_W-1:0] idx,
	                                   input logic [PRIO_REQ_W-1:0] prio);
		req_t c;
		c.command      = cmd;
		c.task_index   = idx;
		c.priority_req = prio;
		return c;
	endfunction

	// Pick one set bit of a slot mask at random
	function automatic logic [SLOT_W-1:0] pick_slot(input logic [TASK_SLOTS-1:0] m);
		int                k;
		logic [SLOT_W-1:0] s;
		k = $urandom_range(0, $countones(m) - 1);
		s = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (m[i]) begin
				if (k == 0)
					s = SLOT_W'(i);
				k--;
			end
		end
		return s;
	endfunction

	// Mostly well-formed commands: inserts aim at created slots that sit
	// in no list, resumes aim at suspended slots. The masks lag the issued
	// stream by an item or so, which only turns a few hits into misses.
	function automatic req_t random_command();
		req_t c;
		int   roll;
		roll           = $urandom_range(0, 99);
		c.task_index   = SLOT_W'($urandom);
		c.priority_req = PRIO_REQ_W'($urandom);
		if (roll < 8) begin
			c.command = CMD_CREATE;
			// favor a few values so equal priorities show up in the ready list
			if ($urandom_range(0, 1) == 1)
				c.priority_req = PRIO_REQ_W'($urandom_range(0, 3) * 85);
		end else if (roll < 28) begin
			c.command = CMD_INSERT;
			if (idle_mask != '0 && $urandom_range(0, 3) != 0)
				c.task_index = pick_slot(idle_mask);
		end else if (roll < 62) begin
			c.command = CMD_SUSPEND;
		end else begin
			c.command = CMD_RESUME;
			if (susp_mask != '0 && $urandom_range(0, 6) != 0)
				c.task_index = pick_slot(susp_mask);
		end
		return c;
	endfunction

	// Offer one item after a random gap; hold it until the block takes it.
	// Valid is left high so a following item can go out back to back.
	task automatic issue(input req_t item);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid and wait until every outstanding result has come back.
	// The first edge lets the checker count the last accepted item.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int ph;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list and wrong-list errors first, then a small
		// ready list built to hit head, tail, middle and equal-priority
		// placement, and suspend/resume through both list ends.
		issue(make_item(CMD_SUSPEND, 4'd0, 8'h00));   // empty ready list
		issue(make_item(CMD_INSERT, 4'd0, 8'h00));    // slot not created yet
		issue(make_item(CMD_RESUME, 4'd15, 8'hFF));   // slot not suspended
		issue(make_item(CMD_CREATE, 4'd0, 8'hFF));    // slot 0, least urgent
		issue(make_item(CMD_CREATE, 4'd0, 8'h00));    // slot 1, most urgent
		issue(make_item(CMD_CREATE, 4'd0, 8'h80));    // slot 2
		issue(make_item(CMD_CREATE, 4'd0, 8'h80));    // slot 3, same as slot 2
		issue(make_item(CMD_INSERT, 4'd1, 8'h00));    // into empty list
		issue(make_item(CMD_SUSPEND, 4'd0, 8'h00));   // single entry stays
		issue(make_item(CMD_INSERT, 4'd0, 8'h00));    // append at tail
		issue(make_item(CMD_INSERT, 4'd2, 8'h00));    // middle
		issue(make_item(CMD_INSERT, 4'd3, 8'h00));    // ahead of equal slot 2
		issue(make_item(CMD_INSERT, 4'd3, 8'h00));    // already listed
		issue(make_item(CMD_INSERT, 4'd9, 8'h00));    // in range, not created
		issue(make_item(CMD_SUSPEND, 4'd0, 8'h00));   // slot 1 suspended
		issue(make_item(CMD_SUSPEND, 4'd0, 8'h00));   // slot 3 on top of it
		issue(make_item(CMD_RESUME, 4'd1, 8'h00));    // suspended tail back to head
		issue(make_item(CMD_RESUME, 4'd2, 8'h00));    // slot in ready, not suspended
		issue(make_item(CMD_RESUME, 4'd3, 8'h00));    // empties suspended list
		issue(make_item(CMD_CREATE, 4'hF, 8'hAA));    // index ignored
		issue(make_item(CMD_SUSPEND, 4'hF, 8'h55));   // index and priority ignored
		drain();

		// Random phases: free running, sender gaps, receiver stalls, both.
		// Drain at each boundary so the sender also pauses on an empty block.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  rx_stall_pct <= 0;  end
				1: begin src_idle_pct = 62; rx_stall_pct <= 0;  end
				2: begin src_idle_pct = 0;  rx_stall_pct <= 62; end
				default: begin src_idle_pct = 38; rx_stall_pct <= 38; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (ph == 0 && n == 150)
					hold_req <= hold_req + 1;
				issue(random_command());
			end
			drain();
		end

		// catch any stray result after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
